>>> rtl/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;
    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int ALIGN_BYTES_DEF  = 16;
    localparam int W = 24;

    localparam logic       CMD_ALLOC   = 1'b0;
    localparam logic       CMD_RELEASE = 1'b1;
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_IGNORED  = 2'd1;
    localparam logic [1:0] ST_OOM      = 2'd2;
    localparam logic [1:0] ST_NO_BLOCK = 2'd3;
    localparam logic       REG_MIN_EXTEND = 1'b0;
    localparam logic       REG_POOL_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_W, S_GROW, S_SPLIT_SH, S_SPLIT_W, S_OFFS,
        S_MERGE_RD, S_MERGE_SH, S_PREV_RD, S_PREV_CHK, S_OUT
    } t_state;
endpackage
`default_nettype wire

>>> rtl/ffba_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ffba_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [23:0] request_bytes;
    logic [23:0] payload_address;
    modport source (output valid, command, request_bytes, payload_address, input ready);
    modport sink   (input valid, command, request_bytes, payload_address, output ready);
endinterface

interface ffba_rsp_if;
    logic        valid;
    logic        ready;
    logic [23:0] granted_address;
    logic [1:0]  status;
    modport source (output valid, granted_address, status, input ready);
    modport sink   (input valid, granted_address, status, output ready);
endinterface

interface ffba_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/first_fit_block_allocator_core.sv
// An ignored request goes straight from idle to the output state, which then sets the
// output valid register; any other request walks the block table: scan, shift and offset
// walk each read the block memory entry by entry.
// Requests are handled one at a time, sequentially.
// A result waits in the output register; the next request waits until it is taken.
// Reset (synchronous, active low) empties the table, zeroes pool length, restores config.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator_core #(
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
    parameter int ALIGN_BYTES  = ffba_pkg::ALIGN_BYTES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ffba_req_if.sink  i_req,
    ffba_rsp_if.source o_rsp,
    ffba_cfg_if.sink  i_cfg
);
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int W  = ffba_pkg::W;
    localparam logic [W+1:0] HDR = (W+2)'(HEADER_BYTES);
    localparam logic [W+1:0] AMASK = (W+2)'(ALIGN_BYTES - 1);
    localparam logic [W+1:0] SPLIT_MIN = (W+2)'(HEADER_BYTES + ALIGN_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    // block memory: {free, size}
    logic [W:0] mem [MAX_BLOCKS];
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [W:0]    wr_data, rd_q;
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_q <= mem[rd_addr];
    end

    ffba_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [W-1:0]  r_used, n_used, r_min_ext, r_limit;
    logic [CW-1:0] r_i, n_i;          // walk index
    logic [AW-1:0] r_tgt, n_tgt;      // block being granted or released
    logic [W+1:0]  r_off, n_off;      // running offset
    logic [W+1:0]  r_sz, n_sz;        // aligned request
    logic [W+1:0]  r_rem, n_rem;      // split remainder, header included
    logic [W-1:0]  r_cur, n_cur;      // size of target block
    logic          r_cmd, n_cmd, r_first, n_first;
    logic [W-1:0]  r_addr, n_addr, r_oaddr, n_oaddr;
    logic [1:0]    r_ost, n_ost;
    logic          r_ovld, n_ovld;

    wire req_fire = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ffba_pkg::S_IDLE) && !r_ovld;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_ovld;
    assign o_rsp.granted_address = r_oaddr;
    assign o_rsp.status = r_ost;

    logic [W+1:0] req_al, ext_al, ext, used_sum;
    always_comb begin
        req_al = ((W+2)'(i_req.request_bytes) + AMASK) & ~AMASK;
        ext_al = (r_sz + HDR + AMASK) & ~AMASK;
        ext = (ext_al < (W+2)'(r_min_ext)) ? (W+2)'(r_min_ext) : ext_al;
        used_sum = (W+2)'(r_used) + ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffba_pkg::S_IDLE;
            r_count <= '0;
            r_used <= '0;
            r_ovld <= 1'b0;
            r_min_ext <= W'(4096);
            r_limit <= W'(1048576);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_used <= n_used;
            r_ovld <= n_ovld;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    ffba_pkg::REG_MIN_EXTEND: r_min_ext <= i_cfg.data;
                    ffba_pkg::REG_POOL_LIMIT: r_limit <= i_cfg.data;
                    default: ;
                endcase
            end
        end
        r_i <= n_i; r_tgt <= n_tgt; r_off <= n_off; r_sz <= n_sz; r_rem <= n_rem;
        r_cur <= n_cur; r_cmd <= n_cmd; r_first <= n_first;
        r_addr <= n_addr; r_oaddr <= n_oaddr; r_ost <= n_ost;
    end

    always_comb begin
        n_state = r_state; n_count = r_count; n_used = r_used; n_ovld = r_ovld;
        n_i = r_i; n_tgt = r_tgt; n_off = r_off; n_sz = r_sz; n_rem = r_rem;
        n_cur = r_cur; n_cmd = r_cmd; n_first = r_first;
        n_addr = r_addr; n_oaddr = r_oaddr; n_ost = r_ost;
        rd_addr = r_i[AW-1:0];
        wr_en = 1'b0; wr_addr = r_tgt; wr_data = rd_q;
        if (r_ovld && o_rsp.ready) n_ovld = 1'b0;
        unique case (r_state)
            ffba_pkg::S_IDLE: begin
                rd_addr = '0;
                if (req_fire) begin
                    n_cmd = i_req.command; n_addr = i_req.payload_address;
                    n_sz = req_al; n_i = '0; n_off = '0; n_first = 1'b1;
                    n_oaddr = '0;
                    if ((i_req.command == ffba_pkg::CMD_ALLOC && i_req.request_bytes == '0)
                        || (i_req.command == ffba_pkg::CMD_RELEASE
                            && i_req.payload_address == '0)) begin
                        n_ost = ffba_pkg::ST_IGNORED; n_state = ffba_pkg::S_OUT;
                    end else begin
                        n_state = ffba_pkg::S_SCAN;
                    end
                end
            end
            // memory addressed by r_i this cycle; data arrives next cycle
            ffba_pkg::S_SCAN: begin
                if (r_i >= r_count) begin
                    if (r_cmd == ffba_pkg::CMD_ALLOC) n_state = ffba_pkg::S_GROW;
                    else begin
                        n_ost = ffba_pkg::ST_NO_BLOCK; n_state = ffba_pkg::S_OUT;
                    end
                end else n_state = ffba_pkg::S_SCAN_W;
            end
            ffba_pkg::S_SCAN_W: begin
                if (r_cmd == ffba_pkg::CMD_ALLOC) begin
                    if (rd_q[W] && (W+2)'(rd_q[W-1:0]) >= r_sz) begin
                        n_tgt = r_i[AW-1:0]; n_cur = rd_q[W-1:0];
                        n_rem = (W+2)'(rd_q[W-1:0]) - r_sz;
                        n_state = ffba_pkg::S_SPLIT_SH;
                    end else begin
                        n_off = r_off + HDR + (W+2)'(rd_q[W-1:0]);
                        n_i = r_i + 1'b1; rd_addr = n_i[AW-1:0];
                        n_state = ffba_pkg::S_SCAN;
                    end
                end else begin
                    if (r_off + HDR == (W+2)'(r_addr)) begin
                        n_tgt = r_i[AW-1:0]; n_cur = rd_q[W-1:0];
                        wr_en = 1'b1; wr_addr = r_i[AW-1:0]; wr_data = {1'b1, rd_q[W-1:0]};
                        n_i = r_i + 1'b1; rd_addr = n_i[AW-1:0];
                        n_state = ffba_pkg::S_MERGE_RD;
                    end else begin
                        n_off = r_off + HDR + (W+2)'(rd_q[W-1:0]);
                        n_i = r_i + 1'b1; rd_addr = n_i[AW-1:0];
                        n_state = ffba_pkg::S_SCAN;
                    end
                end
            end
            ffba_pkg::S_GROW: begin
                if (r_count >= MAXC || used_sum > (W+2)'(r_limit)) begin
                    n_ost = ffba_pkg::ST_OOM; n_state = ffba_pkg::S_OUT;
                end else begin
                    n_tgt = r_count[AW-1:0];
                    n_cur = W'(ext - HDR);
                    n_rem = ext - HDR - r_sz;
                    n_used = used_sum[W-1:0];
                    n_count = r_count + 1'b1;
                    wr_en = 1'b1; wr_addr = r_count[AW-1:0];
                    wr_data = {1'b1, W'(ext - HDR)};
                    n_state = ffba_pkg::S_SPLIT_SH;
                end
            end
            // shift entries tgt+1..count-1 up by one from the top, put remainder at tgt+1, mark tgt used
            ffba_pkg::S_SPLIT_SH: begin
                if (r_rem >= SPLIT_MIN && r_count < MAXC) begin
                    if (r_first) begin
                        n_first = 1'b0; n_i = r_count;
                    end
                    if (n_i > CW'(r_tgt) + 1'b1) begin
                        rd_addr = AW'(n_i - 1'b1);
                        n_state = ffba_pkg::S_SPLIT_W;
                    end else begin
                        wr_en = 1'b1; wr_addr = r_tgt + 1'b1;
                        wr_data = {1'b1, W'(r_rem - HDR)};
                        n_count = r_count + 1'b1;
                        n_rem = '0;
                        n_state = ffba_pkg::S_SPLIT_SH;
                        n_cur = W'(r_sz);
                    end
                end else begin
                    wr_en = 1'b1; wr_addr = r_tgt; wr_data = {1'b0, r_cur};
                    n_i = '0; n_off = '0; rd_addr = '0;
                    n_state = ffba_pkg::S_OFFS;
                end
            end
            ffba_pkg::S_SPLIT_W: begin
                wr_en = 1'b1; wr_addr = r_i[AW-1:0]; wr_data = rd_q;
                n_i = r_i - 1'b1;
                n_state = ffba_pkg::S_SPLIT_SH;
            end
            // offset of tgt: sum over entries below it
            ffba_pkg::S_OFFS: begin
                if (r_first) begin
                    n_first = 1'b0; rd_addr = '0;
                end else if (r_i == CW'(r_tgt)) begin
                    n_oaddr = W'(r_off + HDR);
                    n_ost = ffba_pkg::ST_DONE; n_state = ffba_pkg::S_OUT;
                end else begin
                    n_off = r_off + HDR + (W+2)'(rd_q[W-1:0]);
                    n_i = r_i + 1'b1; rd_addr = n_i[AW-1:0];
                end
            end
            // r_i = tgt+1 is being read
            ffba_pkg::S_MERGE_RD: begin
                if (r_i >= r_count) begin
                    n_state = ffba_pkg::S_PREV_RD;
                end else begin
                    n_state = ffba_pkg::S_MERGE_SH; n_first = 1'b1;
                end
            end
            ffba_pkg::S_MERGE_SH: begin
                if (r_first) begin
                    n_first = 1'b0;
                    if (!rd_q[W]) n_state = ffba_pkg::S_PREV_RD;
                    else begin
                        n_cur = W'((W+2)'(r_cur) + HDR + (W+2)'(rd_q[W-1:0]));
                        wr_en = 1'b1; wr_addr = r_tgt;
                        wr_data = {1'b1, n_cur};
                        n_i = r_i + 1'b1; rd_addr = n_i[AW-1:0];
                    end
                end else if (r_i >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = ffba_pkg::S_PREV_RD;
                end else begin
                    // copy entry i down to i-1
                    wr_en = 1'b1; wr_addr = AW'(r_i - 1'b1); wr_data = rd_q;
                    n_i = r_i + 1'b1; rd_addr = n_i[AW-1:0];
                end
            end
            ffba_pkg::S_PREV_RD: begin
                if (r_tgt == '0) begin
                    n_ost = ffba_pkg::ST_DONE; n_state = ffba_pkg::S_OUT;
                end else begin
                    rd_addr = r_tgt - 1'b1;
                    n_state = ffba_pkg::S_PREV_CHK;
                end
            end
            ffba_pkg::S_PREV_CHK: begin
                if (!rd_q[W]) begin
                    n_ost = ffba_pkg::ST_DONE; n_state = ffba_pkg::S_OUT;
                end else begin
                    // treat previous block as target and absorb the current one
                    n_cur = rd_q[W-1:0];
                    n_tgt = r_tgt - 1'b1;
                    n_i = CW'(r_tgt); rd_addr = r_tgt;
                    n_first = 1'b1;
                    n_state = ffba_pkg::S_MERGE_SH;
                end
            end
            ffba_pkg::S_OUT: begin
                if (!r_ovld) begin
                    n_ovld = 1'b1; n_state = ffba_pkg::S_IDLE;
                end
            end
            default: n_state = ffba_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/ffba_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ffba_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [23:0] rsp_addr,
    input wire logic [1:0]  rsp_status
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_addr) && $stable(rsp_status))
        else $error("held result changed");
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_status != ffba_pkg::ST_DONE |-> rsp_addr == '0)
        else $error("address on failed request");
    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |-> !rsp_valid)
        else $error("request taken while result pending");
    a_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request while busy");
endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready),
    .rsp_valid(o_rsp.valid), .rsp_ready(o_rsp.ready),
    .rsp_addr(o_rsp.granted_address), .rsp_status(o_rsp.status)
);
`default_nettype wire
